FILE: rtl/core/banker_resource_allocator_assert.svh
// Assertion macros shared by the allocator RTL.
// Needs signals named clock and reset in the including module.
`ifndef BANKER_RESOURCE_ALLOCATOR_ASSERT_SVH
`define BANKER_RESOURCE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define BRA_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define BRA_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/bra_pkg.sv
// Shared constants, codes and control types of the allocator.
// No dependencies; imported by bra_datapath, banker_resource_allocator and the testbench.
package bra_pkg;

   localparam int DEF_NUM_CUSTOMERS = 5;
   localparam int DEF_NUM_RESOURCES = 3;
   localparam int DEF_AMOUNT_BITS   = 8;

   localparam int FIELD_W  = 24;  // packed amount fields
   localparam int LANE_W   = 8;   // byte spacing of one resource lane
   localparam int TYPE_W   = 3;
   localparam int STATUS_W = 3;
   localparam int IDX_W    = 3;   // customer or resource index, max count 8

   // Operation codes of req_type
   localparam logic [TYPE_W-1:0] OP_RESTART  = 3'd0;
   localparam logic [TYPE_W-1:0] OP_LOAD_MAX = 3'd1;
   localparam logic [TYPE_W-1:0] OP_REQUEST  = 3'd2;
   localparam logic [TYPE_W-1:0] OP_RELEASE  = 3'd3;
   localparam logic [TYPE_W-1:0] OP_SAFETY   = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EXCEEDS_NEED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NO_UNITS     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OVER_RELEASE = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BAD_CUSTOMER = 3'd4;

   // Datapath operations issued by the sequencer
   typedef enum logic [2:0] {
      DP_NONE      = 3'd0,
      DP_RESTART   = 3'd1,
      DP_LOAD      = 3'd2,
      DP_REQ_APPLY = 3'd3,
      DP_REL_APPLY = 3'd4,
      DP_WORK_INIT = 3'd5,
      DP_WORK_ADD  = 3'd6
   } dp_op_type;

   typedef struct packed {
      dp_op_type         op;
      logic [IDX_W-1:0]  cust;
      logic [IDX_W-1:0]  res;
      logic [LANE_W-1:0] amount;
   } dp_ctrl_type;

   typedef struct packed {
      logic q_gt_need;
      logic q_gt_pool;
      logic q_gt_alloc;
      logic need_gt_work;
      logic cust_done;
      logic all_done;
   } dp_stat_type;

   // Pick one byte lane of a packed field; lanes past the field read zero
   function automatic logic [LANE_W-1:0] lane_sel(input logic [FIELD_W-1:0] packed_v,
                                                  input logic [IDX_W-1:0]   r);
      logic [FIELD_W-1:0] shifted;
      shifted = packed_v >> (LANE_W * int'(r));
      return shifted[LANE_W-1:0];
   endfunction

endpackage

FILE: rtl/core/banker_resource_allocator.sv
// Banker's-algorithm allocator: one operation per transfer, one result each.
// Steps after acceptance: restart, bad customer and unknown op go straight to the result; load
// maximum writes each resource; request/release checks each resource, stopping at the first
// failure, then applies each; safety makes up to C passes (C customers), one entry per cycle.
// One item at a time: req_ready is high only while the sequencer is idle.
// Synchronous reset clears pool, tables and the register to zero at once; no clearing pass.
`include "banker_resource_allocator_assert.svh"

module banker_resource_allocator
   import bra_pkg::*;
#(
   parameter int NUM_CUSTOMERS = DEF_NUM_CUSTOMERS,
   parameter int NUM_RESOURCES = DEF_NUM_RESOURCES,
   parameter int AMOUNT_BITS   = DEF_AMOUNT_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [FIELD_W-1:0]  csr_wr_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [TYPE_W-1:0]   req_type,
   input  logic [IDX_W-1:0]    req_customer,
   input  logic [FIELD_W-1:0]  req_amounts,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_safe
);

   localparam int CW = (NUM_CUSTOMERS > 1) ? $clog2(NUM_CUSTOMERS) : 1;
   localparam int RW = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
   localparam logic [IDX_W:0] CUST_LIMIT = (IDX_W + 1)'(NUM_CUSTOMERS);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_LOAD  = 8'b0000_0010,
      S_CHECK = 8'b0000_0100,
      S_APPLY = 8'b0000_1000,
      S_FIT   = 8'b0001_0000,
      S_ADD   = 8'b0010_0000,
      S_PASS  = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } state_type;

   state_type           state_ff, state_in;
   logic [FIELD_W-1:0]  init_avail_ff, init_avail_in;
   logic [TYPE_W-1:0]   op_ff, op_in;
   logic [FIELD_W-1:0]  amounts_ff, amounts_in;
   logic [CW-1:0]       cust_ff, cust_in;
   logic [RW-1:0]       res_ff, res_in;
   logic                changed_ff, changed_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                res_safe_ff, res_safe_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_safe_ff, rsp_safe_in;

   logic        req_xfer;
   logic        rsp_load;
   logic        advance_cust;
   logic        res_last;
   logic        cust_last;
   logic        bad_cust;
   dp_ctrl_type dp_ctrl;
   dp_stat_type dp_stat;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_xfer   = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_safe   = rsp_safe_ff;

   assign res_last  = (res_ff == RW'(NUM_RESOURCES - 1));
   assign cust_last = (cust_ff == CW'(NUM_CUSTOMERS - 1));
   assign bad_cust  = ({1'b0, req_customer} >= CUST_LIMIT);

   // Drive the shared datapath unit
   always_comb begin
      dp_ctrl.op     = DP_NONE;
      dp_ctrl.cust   = IDX_W'(cust_ff);
      dp_ctrl.res    = IDX_W'(res_ff);
      dp_ctrl.amount = lane_sel(amounts_ff, IDX_W'(res_ff));
      case (state_ff)
         S_IDLE: begin
            if (req_xfer && req_type == OP_RESTART) begin
               dp_ctrl.op = DP_RESTART;
            end else if (req_xfer && req_type == OP_SAFETY) begin
               dp_ctrl.op = DP_WORK_INIT;
            end
         end
         S_LOAD:  dp_ctrl.op = DP_LOAD;
         S_APPLY: dp_ctrl.op = (op_ff == OP_REQUEST) ? DP_REQ_APPLY : DP_REL_APPLY;
         S_ADD:   dp_ctrl.op = DP_WORK_ADD;
         default: dp_ctrl.op = DP_NONE;
      endcase
   end

   bra_datapath #(
      .NUM_CUSTOMERS (NUM_CUSTOMERS),
      .NUM_RESOURCES (NUM_RESOURCES),
      .AMOUNT_BITS   (AMOUNT_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .init_avail (init_avail_ff),
      .ctrl       (dp_ctrl),
      .stat       (dp_stat)
   );

   // Sequencer: step resources, then customers, then passes
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      amounts_in    = amounts_ff;
      cust_in       = cust_ff;
      res_in        = res_ff;
      changed_in    = changed_ff;
      res_status_in = res_status_ff;
      res_safe_in   = res_safe_ff;
      advance_cust  = 1'b0;
      rsp_load      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               op_in         = req_type;
               amounts_in    = req_amounts;
               cust_in       = req_customer[CW-1:0];
               res_in        = '0;
               res_status_in = ST_OK;
               res_safe_in   = 1'b0;
               state_in      = S_DONE;
               if (req_type == OP_LOAD_MAX || req_type == OP_REQUEST ||
                   req_type == OP_RELEASE) begin
                  if (bad_cust) begin
                     res_status_in = ST_BAD_CUSTOMER;
                  end else if (req_type == OP_LOAD_MAX) begin
                     state_in = S_LOAD;
                  end else begin
                     state_in = S_CHECK;
                  end
               end else if (req_type == OP_SAFETY) begin
                  cust_in    = '0;
                  changed_in = 1'b0;
                  state_in   = S_FIT;
               end
            end
         end
         S_LOAD: begin
            res_in = res_ff + 1'b1;
            if (res_last) begin
               state_in = S_DONE;
            end
         end
         S_CHECK: begin
            res_in = res_ff + 1'b1;
            if (op_ff == OP_REQUEST && dp_stat.q_gt_need) begin
               res_status_in = ST_EXCEEDS_NEED;
               state_in      = S_DONE;
            end else if (op_ff == OP_REQUEST && dp_stat.q_gt_pool) begin
               res_status_in = ST_NO_UNITS;
               state_in      = S_DONE;
            end else if (op_ff == OP_RELEASE && dp_stat.q_gt_alloc) begin
               res_status_in = ST_OVER_RELEASE;
               state_in      = S_DONE;
            end else if (res_last) begin
               res_in   = '0;
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            res_in = res_ff + 1'b1;
            if (res_last) begin
               state_in = S_DONE;
            end
         end
         S_FIT: begin
            res_in = res_ff + 1'b1;
            if (dp_stat.cust_done || dp_stat.need_gt_work) begin
               advance_cust = 1'b1;
            end else if (res_last) begin
               res_in   = '0;
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            res_in     = res_ff + 1'b1;
            changed_in = 1'b1;
            if (res_last) begin
               advance_cust = 1'b1;
            end
         end
         S_PASS: begin
            // Run another pass only while something still moves
            if (changed_ff && !dp_stat.all_done) begin
               changed_in = 1'b0;
               cust_in    = '0;
               res_in     = '0;
               state_in   = S_FIT;
            end else begin
               res_safe_in = dp_stat.all_done;
               state_in    = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // Move to the next customer, or close the pass
      if (advance_cust) begin
         res_in = '0;
         if (cust_last) begin
            state_in = S_PASS;
         end else begin
            cust_in  = cust_ff + 1'b1;
            state_in = S_FIT;
         end
      end
   end

   // Output register: hold until the transfer completes
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_safe_in   = rsp_safe_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_safe_in   = res_safe_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign init_avail_in = csr_wr_en ? csr_wr_data : init_avail_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         init_avail_ff <= '0;
         changed_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         init_avail_ff <= init_avail_in;
         changed_ff    <= changed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      amounts_ff    <= amounts_in;
      cust_ff       <= cust_in;
      res_ff        <= res_in;
      res_status_ff <= res_status_in;
      res_safe_ff   <= res_safe_in;
      rsp_status_ff <= rsp_status_in;
      rsp_safe_ff   <= rsp_safe_in;
   end

   // Checks on the sequencer
   `BRA_ASSERT_NXT(a_busy_after_accept, req_xfer, !req_ready, "ready stayed high after accept")
   `BRA_ASSERT_IMP(a_rsp_from_done, rsp_valid_ff && !$past(rsp_valid_ff), $past(state_ff == S_DONE), "result appeared outside done state")
   `BRA_ASSERT_IMP(a_safe_only_query, state_ff == S_DONE && res_safe_ff, op_ff == OP_SAFETY, "safe flag set for a non-query operation")
   `BRA_ASSERT_IMP(a_query_status_ok, state_ff == S_DONE && op_ff == OP_SAFETY, res_status_ff == ST_OK, "safety query gave an error status")

endmodule

FILE: rtl/core/bra_datapath.sv
// Allocator state (pool, allocation, need, safety work row) and the shared compare /
// add-subtract unit; one entry per cycle except restart and work setup. Uses bra_pkg.
module bra_datapath
   import bra_pkg::*;
#(
   parameter int NUM_CUSTOMERS = DEF_NUM_CUSTOMERS,
   parameter int NUM_RESOURCES = DEF_NUM_RESOURCES,
   parameter int AMOUNT_BITS   = DEF_AMOUNT_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [FIELD_W-1:0] init_avail,
   input  dp_ctrl_type        ctrl,
   output dp_stat_type        stat
);

   localparam int CW = (NUM_CUSTOMERS > 1) ? $clog2(NUM_CUSTOMERS) : 1;
   localparam int RW = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
   localparam int AB = AMOUNT_BITS;
   // working pool never saturates: pool plus every allocation row
   localparam int WB = AB + $clog2(NUM_CUSTOMERS + 1);

   logic [AB-1:0] pool_ff  [NUM_RESOURCES];
   logic [AB-1:0] pool_in  [NUM_RESOURCES];
   logic [AB-1:0] alloc_ff [NUM_CUSTOMERS][NUM_RESOURCES];
   logic [AB-1:0] alloc_in [NUM_CUSTOMERS][NUM_RESOURCES];
   logic [AB-1:0] need_ff  [NUM_CUSTOMERS][NUM_RESOURCES];
   logic [AB-1:0] need_in  [NUM_CUSTOMERS][NUM_RESOURCES];
   logic [WB-1:0] work_ff  [NUM_RESOURCES];
   logic [WB-1:0] work_in  [NUM_RESOURCES];
   logic [NUM_CUSTOMERS-1:0] done_ff;
   logic [NUM_CUSTOMERS-1:0] done_in;

   logic [CW-1:0] ci;
   logic [RW-1:0] ri;
   logic [AB-1:0] q;
   logic [AB-1:0] pool_sel;
   logic [AB-1:0] alloc_sel;
   logic [AB-1:0] need_sel;
   logic [WB-1:0] work_sel;
   logic [AB:0]   pool_sum;
   logic [AB:0]   need_sum;

   // Select the one entry the sequencer points at
   assign ci        = ctrl.cust[CW-1:0];
   assign ri        = ctrl.res[RW-1:0];
   assign q         = ctrl.amount[AB-1:0];
   assign pool_sel  = pool_ff[ri];
   assign alloc_sel = alloc_ff[ci][ri];
   assign need_sel  = need_ff[ci][ri];
   assign work_sel  = work_ff[ri];
   assign pool_sum  = {1'b0, pool_sel} + {1'b0, q};
   assign need_sum  = {1'b0, need_sel} + {1'b0, q};

   // Compare results for the sequencer
   assign stat.q_gt_need    = q > need_sel;
   assign stat.q_gt_pool    = q > pool_sel;
   assign stat.q_gt_alloc   = q > alloc_sel;
   assign stat.need_gt_work = WB'(need_sel) > work_sel;
   assign stat.cust_done    = done_ff[ci];
   assign stat.all_done     = &done_ff;

   // Apply the selected operation
   always_comb begin
      pool_in  = pool_ff;
      alloc_in = alloc_ff;
      need_in  = need_ff;
      work_in  = work_ff;
      done_in  = done_ff;
      case (ctrl.op)
         DP_RESTART: begin
            for (int r = 0; r < NUM_RESOURCES; r++) begin
               pool_in[r] = AB'(lane_sel(init_avail, IDX_W'(r)));
            end
         end
         DP_LOAD: begin
            need_in[ci][ri] = (q > alloc_sel) ? (q - alloc_sel) : '0;
         end
         DP_REQ_APPLY: begin
            pool_in[ri]      = pool_sel - q;
            alloc_in[ci][ri] = alloc_sel + q;
            need_in[ci][ri]  = need_sel - q;
         end
         DP_REL_APPLY: begin
            pool_in[ri]      = pool_sum[AB] ? '1 : pool_sum[AB-1:0];
            alloc_in[ci][ri] = alloc_sel - q;
            need_in[ci][ri]  = need_sum[AB] ? '1 : need_sum[AB-1:0];
         end
         DP_WORK_INIT: begin
            for (int r = 0; r < NUM_RESOURCES; r++) begin
               work_in[r] = WB'(pool_ff[r]);
            end
            done_in = '0;
         end
         DP_WORK_ADD: begin
            work_in[ri] = work_sel + WB'(alloc_sel);
            done_in[ci] = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_RESOURCES; r++) begin
            pool_ff[r] <= '0;
            work_ff[r] <= '0;
         end
         for (int c = 0; c < NUM_CUSTOMERS; c++) begin
            for (int r = 0; r < NUM_RESOURCES; r++) begin
               alloc_ff[c][r] <= '0;
               need_ff[c][r]  <= '0;
            end
         end
         done_ff <= '0;
      end else begin
         pool_ff  <= pool_in;
         alloc_ff <= alloc_in;
         need_ff  <= need_in;
         work_ff  <= work_in;
         done_ff  <= done_in;
      end
   end

endmodule

FILE: tb/allocator_ledger_check.sv
// Checker for banker_resource_allocator: watches the request, result and register ports,
// keeps its own copy of pool, maximum, allocation and need tables, and compares each result.
// Depends on bra_pkg for widths and codes.
`timescale 1ns / 1ps

module allocator_ledger_check
   import bra_pkg::*;
#(
   parameter int NUM_CUSTOMERS = DEF_NUM_CUSTOMERS,
   parameter int NUM_RESOURCES = DEF_NUM_RESOURCES,
   parameter int AMOUNT_BITS   = DEF_AMOUNT_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [FIELD_W-1:0]  csr_wr_data,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [TYPE_W-1:0]   req_type,
   input  logic [IDX_W-1:0]    req_customer,
   input  logic [FIELD_W-1:0]  req_amounts,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic                rsp_safe,
   output int                  fail_count,
   output int                  outcomes_due,
   output int                  outcomes_checked,
   output int                  safe_answers
);

   typedef logic [AMOUNT_BITS-1:0] units_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                safe;
   } outcome_type;

   localparam units_type UNITS_MAX = '1;

   logic [FIELD_W-1:0] pool_totals;
   units_type          pool      [NUM_RESOURCES];
   units_type          max_units [NUM_CUSTOMERS][NUM_RESOURCES];
   units_type          held      [NUM_CUSTOMERS][NUM_RESOURCES];
   units_type          need      [NUM_CUSTOMERS][NUM_RESOURCES];
   outcome_type        due_q[$];

   // Unit count of resource r in a packed field; lanes past the field read zero
   function automatic units_type units_of(input logic [FIELD_W-1:0] packed_v, input int r);
      logic [FIELD_W-1:0] shifted;
      shifted = packed_v >> (LANE_W * r);
      return shifted[AMOUNT_BITS-1:0];
   endfunction

   function automatic units_type add_clamped(input units_type a, input units_type b);
      logic [AMOUNT_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[AMOUNT_BITS] ? UNITS_MAX : sum[AMOUNT_BITS-1:0];
   endfunction

   // Repeat passes until no customer can finish; the working pool never saturates
   function automatic bit state_is_safe();
      int work     [NUM_RESOURCES];
      bit finished [NUM_CUSTOMERS];
      bit progress;
      bit fits;
      for (int r = 0; r < NUM_RESOURCES; r++) work[r] = int'(pool[r]);
      for (int c = 0; c < NUM_CUSTOMERS; c++) finished[c] = 1'b0;
      progress = 1'b1;
      while (progress) begin
         progress = 1'b0;
         for (int c = 0; c < NUM_CUSTOMERS; c++) begin
            fits = !finished[c];
            for (int r = 0; r < NUM_RESOURCES; r++)
               if (fits && int'(need[c][r]) > work[r]) fits = 1'b0;
            if (fits) begin
               for (int r = 0; r < NUM_RESOURCES; r++) work[r] += int'(held[c][r]);
               finished[c] = 1'b1;
               progress = 1'b1;
            end
         end
      end
      for (int c = 0; c < NUM_CUSTOMERS; c++)
         if (!finished[c]) return 1'b0;
      return 1'b1;
   endfunction

   // Apply one operation to the ledger and return the result it must produce
   function automatic outcome_type ledger_apply(input logic [TYPE_W-1:0]  op,
                                                input logic [IDX_W-1:0]   cust,
                                                input logic [FIELD_W-1:0] amt);
      outcome_type res;
      units_type   q;
      int          c;
      res.status = ST_OK;
      res.safe   = 1'b0;
      c = int'(cust);
      if (op == OP_RESTART) begin
         for (int r = 0; r < NUM_RESOURCES; r++) pool[r] = units_of(pool_totals, r);
      end else if (op == OP_SAFETY) begin
         res.safe = state_is_safe();
      end else if (op == OP_LOAD_MAX || op == OP_REQUEST || op == OP_RELEASE) begin
         if (c >= NUM_CUSTOMERS) begin
            res.status = ST_BAD_CUSTOMER;
         end else if (op == OP_LOAD_MAX) begin
            for (int r = 0; r < NUM_RESOURCES; r++) begin
               q = units_of(amt, r);
               max_units[c][r] = q;
               need[c][r] = (q > held[c][r]) ? q - held[c][r] : '0;
            end
         end else if (op == OP_REQUEST) begin
            // first failing resource decides the code; nothing changes on error
            for (int r = 0; r < NUM_RESOURCES; r++) begin
               q = units_of(amt, r);
               if (res.status == ST_OK) begin
                  if (q > need[c][r]) res.status = ST_EXCEEDS_NEED;
                  else if (q > pool[r]) res.status = ST_NO_UNITS;
               end
            end
            if (res.status == ST_OK) begin
               for (int r = 0; r < NUM_RESOURCES; r++) begin
                  q = units_of(amt, r);
                  pool[r]    -= q;
                  held[c][r] += q;
                  need[c][r] -= q;
               end
            end
         end else begin
            for (int r = 0; r < NUM_RESOURCES; r++)
               if (units_of(amt, r) > held[c][r]) res.status = ST_OVER_RELEASE;
            if (res.status == ST_OK) begin
               for (int r = 0; r < NUM_RESOURCES; r++) begin
                  q = units_of(amt, r);
                  pool[r]    = add_clamped(pool[r], q);
                  held[c][r] -= q;
                  need[c][r] = add_clamped(need[c][r], q);
               end
            end
         end
      end
      return res;
   endfunction

   // Compare result transfers first, then log the expectation of a new request
   always @(posedge clock) begin : watch
      outcome_type got;
      outcome_type want;
      if (reset) begin
         pool_totals = '0;
         for (int r = 0; r < NUM_RESOURCES; r++) pool[r] = '0;
         for (int c = 0; c < NUM_CUSTOMERS; c++)
            for (int r = 0; r < NUM_RESOURCES; r++) begin
               max_units[c][r] = '0;
               held[c][r]      = '0;
               need[c][r]      = '0;
            end
         due_q.delete();
      end else begin
         if (csr_wr_en) pool_totals = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            got.status = rsp_status;
            got.safe   = rsp_safe;
            outcomes_checked++;
            if (due_q.size() == 0) begin
               fail_count++;
               $error("unexpected result transfer: status %0d safe %0d", got.status, got.safe);
            end else begin
               want = due_q.pop_front();
               if (want.safe) safe_answers++;
               if (got.status !== want.status) begin
                  fail_count++;
                  $error("status: expected %0d, actual %0d", want.status, got.status);
               end
               if (got.safe !== want.safe) begin
                  fail_count++;
                  $error("safe: expected %0d, actual %0d", want.safe, got.safe);
               end
            end
         end
         if (req_valid && req_ready)
            due_q.push_back(ledger_apply(req_type, req_customer, req_amounts));
      end
      outcomes_due = due_q.size();
   end

endmodule

FILE: tb/banker_resource_allocator_test.sv
// Top of the allocator testbench: clock, reset, stimulus on the request and register ports,
// random stalls on the result port and the verdict. Depends on bra_pkg, the RTL and
// allocator_ledger_check.
`timescale 1ns / 1ps

module banker_resource_allocator_test;
   import bra_pkg::*;

   localparam int NC          = DEF_NUM_CUSTOMERS;
   localparam int NR          = DEF_NUM_RESOURCES;
   localparam int AB          = DEF_AMOUNT_BITS;
   localparam int TYPE_MAX    = (1 << TYPE_W) - 1;
   localparam int IDX_MAX     = (1 << IDX_W) - 1;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 145;
   localparam int TAIL_CYCLES = 250;
   localparam int LIMIT       = 2_000_000;

   logic                clock        = 1'b0;
   logic                reset        = 1'b1;
   logic                csr_wr_en    = 1'b0;
   logic [FIELD_W-1:0]  csr_wr_data  = '0;
   logic                req_valid    = 1'b0;
   logic                req_ready;
   logic [TYPE_W-1:0]   req_type     = OP_RESTART;
   logic [IDX_W-1:0]    req_customer = '0;
   logic [FIELD_W-1:0]  req_amounts  = '0;
   logic                rsp_valid;
   logic                rsp_ready    = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_safe;

   int fail_count;
   int outcomes_due;
   int outcomes_checked;
   int safe_answers;

   int cycles       = 0;
   int stall_left   = 0;
   int settings     = 0;
   int sent_by_op [TYPE_MAX+1];
   bit calm         = 1'b0;

   banker_resource_allocator #(
      .NUM_CUSTOMERS(NC),
      .NUM_RESOURCES(NR),
      .AMOUNT_BITS  (AB)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_type    (req_type),
      .req_customer(req_customer),
      .req_amounts (req_amounts),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_status  (rsp_status),
      .rsp_safe    (rsp_safe)
   );

   allocator_ledger_check #(
      .NUM_CUSTOMERS(NC),
      .NUM_RESOURCES(NR),
      .AMOUNT_BITS  (AB)
   ) ledger (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_customer    (req_customer),
      .req_amounts     (req_amounts),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_safe        (rsp_safe),
      .fail_count      (fail_count),
      .outcomes_due    (outcomes_due),
      .outcomes_checked(outcomes_checked),
      .safe_answers    (safe_answers)
   );

   always #2 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("banker_resource_allocator_test: FAIL");
         $finish;
      end
   end

   // Idle length: mostly none or short, now and then long, none in calm stretches
   function automatic int idle_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (calm || pick < 55) return 0;
      if (pick < 88) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // Stall the result side at random
   always @(posedge clock) begin : rsp_stall
      int gap;
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else begin
         gap = idle_len();
         rsp_ready  <= (gap == 0);
         stall_left <= (gap > 0) ? gap - 1 : 0;
      end
   end

   // Pack a random count from 0 to hi into each resource lane
   function automatic logic [FIELD_W-1:0] lanes_upto(input int hi);
      logic [FIELD_W-1:0] v;
      v = '0;
      for (int r = 0; r < NR; r++) v[LANE_W*r +: LANE_W] = LANE_W'($urandom_range(0, hi));
      return v;
   endfunction

   // Idle a while, then hold the item until its transfer
   task automatic send_op(input logic [TYPE_W-1:0]  op,
                          input logic [IDX_W-1:0]   cust,
                          input logic [FIELD_W-1:0] amt);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_type     <= op;
      req_customer <= cust;
      req_amounts  <= amt;
      do @(posedge clock); while (!req_ready);
      sent_by_op[op]++;
   endtask

   // Drop valid and wait until every expected result has come back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outcomes_due != 0) @(posedge clock);
   endtask

   task automatic write_totals(input logic [FIELD_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      settings++;
   endtask

   initial begin
      int pick;
      logic [FIELD_W-1:0] totals;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Empty pool: zero state is safe, then every error code
      write_totals('0);
      send_op(OP_SAFETY, 3'd3, 24'hFFFFFF);
      send_op(OP_RESTART, 3'd7, 24'h5A5A5A);
      send_op(OP_LOAD_MAX, 3'd0, 24'h030201);
      send_op(OP_REQUEST, 3'd0, 24'h000001);
      send_op(OP_REQUEST, 3'd0, 24'h000005);
      send_op(OP_SAFETY, 3'd0, 24'h000000);
      send_op(OP_RELEASE, 3'd0, 24'h000001);
      send_op(OP_LOAD_MAX, 3'd5, 24'h010101);
      send_op(OP_REQUEST, 3'd7, 24'h000000);
      send_op(OP_RELEASE, 3'd6, 24'h000000);
      send_op(OP_SAFETY + 3'd1, 3'd1, 24'h123456);
      send_op(TYPE_W'(TYPE_MAX), 3'd2, 24'hFFFFFF);
      settle();

      // Full pool: grants, a late exceeds-need lane, pool saturation
      write_totals('1);
      send_op(OP_RESTART, 3'd0, 24'h000000);
      send_op(OP_LOAD_MAX, 3'd0, 24'hFFFFFF);
      send_op(OP_LOAD_MAX, IDX_W'(NC - 1), 24'h102030);
      send_op(OP_REQUEST, 3'd0, 24'h0A0B0C);
      send_op(OP_REQUEST, IDX_W'(NC - 1), 24'h102030);
      send_op(OP_REQUEST, 3'd0, 24'hFF0000);
      send_op(OP_RESTART, 3'd4, 24'h000000);
      send_op(OP_RELEASE, 3'd0, 24'h0A0B0C);
      send_op(OP_LOAD_MAX, IDX_W'(NC - 1), 24'h000000);
      send_op(OP_SAFETY, 3'd0, 24'h000000);
      send_op(OP_RELEASE, IDX_W'(NC - 1), 24'h102030);
      settle();

      // Random phases: restart, load every maximum, then mostly sane traffic
      for (int p = 0; p < PHASES; p++) begin
         case (p % 5)
            0: totals = '1;
            1: totals = FIELD_W'($urandom);
            2: totals = lanes_upto(60);
            3: totals = lanes_upto(6);
            default: totals = '0;
         endcase
         write_totals(totals);
         send_op(OP_RESTART, IDX_W'($urandom_range(0, IDX_MAX)), FIELD_W'($urandom));
         for (int c = 0; c < NC; c++)
            send_op(OP_LOAD_MAX, IDX_W'(c), lanes_upto($urandom_range(4, 40)));
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 50 == 0) calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 35)
               send_op(OP_REQUEST, IDX_W'($urandom_range(0, NC - 1)),
                       lanes_upto($urandom_range(1, 6)));
            else if (pick < 55)
               send_op(OP_RELEASE, IDX_W'($urandom_range(0, NC - 1)), lanes_upto(3));
            else if (pick < 70)
               send_op(OP_SAFETY, IDX_W'($urandom_range(0, IDX_MAX)), FIELD_W'($urandom));
            else if (pick < 77)
               send_op(OP_LOAD_MAX, IDX_W'($urandom_range(0, NC - 1)), lanes_upto(40));
            else if (pick < 82)
               send_op(OP_RESTART, IDX_W'($urandom_range(0, IDX_MAX)), FIELD_W'($urandom));
            else
               send_op(TYPE_W'($urandom_range(0, TYPE_MAX)),
                       IDX_W'($urandom_range(0, IDX_MAX)), FIELD_W'($urandom));
         end
         settle();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      @(negedge clock);
      if (outcomes_due != 0) $error("%0d results never arrived", outcomes_due);

      $display("Ran %0d register settings; sent %0d requests, %0d releases, %0d loads, %0d restarts",
               settings, sent_by_op[OP_REQUEST], sent_by_op[OP_RELEASE],
               sent_by_op[OP_LOAD_MAX], sent_by_op[OP_RESTART]);
      $display("and %0d safety queries (%0d answered safe); %0d results compared",
               sent_by_op[OP_SAFETY], safe_answers, outcomes_checked);
      if (fail_count == 0 && outcomes_due == 0) begin
         $display("banker_resource_allocator_test: PASS");
      end else begin
         $display("banker_resource_allocator_test: FAIL");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/bra_pkg.sv
rtl/core/bra_datapath.sv
rtl/core/banker_resource_allocator.sv
tb/allocator_ledger_check.sv
tb/banker_resource_allocator_test.sv
